// ===== src/ddt_pkg.sv =====
// ----------------------------------------------------------------------------
// ddt_pkg: shared types and constants of the detection dedup table
// Table geometry, field widths, status codes and the coordinate helper.
// ----------------------------------------------------------------------------
package ddt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int COORD_W     = 16;
  localparam int POS_W       = 3 * COORD_W;
  localparam int TOL_W       = 15;
  localparam int LIM_W       = 36;
  localparam int PROD_W      = 2 * COORD_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 36;

  localparam int STATUS_W    = 3;
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_CNT_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SQ  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RESET   = 15'd256;
  localparam logic [LIM_W-1:0] RANGE_RESET = 36'd589824;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        mag_t;

  // Magnitude of the difference of two signed coordinates. It never exceeds
  // 65535, so it fits the coordinate width as an unsigned value.
  function automatic mag_t abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

// ===== src/ddt_ram.sv =====
// ----------------------------------------------------------------------------
// ddt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ddt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/detection_dedup_table_top.sv =====
// ----------------------------------------------------------------------------
// detection_dedup_table_top: table of accepted 3-D detections
// Rejects duplicates inside a per-axis tolerance box, gates on squared range
// to the robot and appends new detections to a table held in RAM.
//
//   Channel  Signals                            Direction  Transfer when
//   in       in_valid, in_stall, det_*, robot_*  in         valid & !stall
//   out      out_valid, out_stall, status, ...   out        valid & !stall
//   cfg      cfg_valid, cfg_ready, cfg_index/data in         valid & ready
//
// An invalid detection goes from the accepting cycle straight to the result
// state. A valid detection passes through the squared-distance unit (one shared
// 16x16 multiplier, one axis per cycle), then scans the table RAM one entry per
// cycle, then enters the result state; a duplicate ends the scan early. A new
// item is taken only when idle, so each item finishes before the next one.
// Reset is synchronous and empties the table; there is no clearing pass.
// A stalled output holds its result, and the input stays stalled until the
// pending result moves into the output register.
// ----------------------------------------------------------------------------
module detection_dedup_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          det_invalid,
  input  ddt_pkg::coord_t               det_x,
  input  ddt_pkg::coord_t               det_y,
  input  ddt_pkg::coord_t               det_z,
  input  ddt_pkg::coord_t               robot_x,
  input  ddt_pkg::coord_t               robot_y,
  input  ddt_pkg::coord_t               robot_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ddt_pkg::STATUS_W-1:0]  status,
  output logic [ddt_pkg::OUT_IDX_W-1:0] entry_index,
  output logic [ddt_pkg::OUT_CNT_W-1:0] entry_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ddt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIST = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]          state;
  logic [TOL_W-1:0]    match_tol;
  logic [LIM_W-1:0]    range_sq;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic [1:0]          axis;

  coord_t              dx, dy, dz, rx, ry, rz;
  logic [PROD_W-1:0]   prod;
  logic [LIM_W-1:0]    dist_acc;
  mag_t                axis_mag;

  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;
  logic [POS_W-1:0]    rd_data;
  logic                rd_en;
  logic                wr_en;
  logic                hit;
  logic                scan_done;
  logic                out_load;

  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [CNT_W-1:0]    res_count;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Shared distance unit operand: one axis per cycle.
  always_comb begin
    case (axis)
      2'd0:    axis_mag = abs_diff(dx, rx);
      2'd1:    axis_mag = abs_diff(dy, ry);
      default: axis_mag = abs_diff(dz, rz);
    endcase
  end

  assign hit = rd_valid &&
               ({1'b0, abs_diff(coord_t'(rd_data[POS_W-1 -: COORD_W]), dx)} <=
                {1'b0, match_tol}) &&
               ({1'b0, abs_diff(coord_t'(rd_data[2*COORD_W-1 -: COORD_W]), dy)} <=
                {1'b0, match_tol}) &&
               ({1'b0, abs_diff(coord_t'(rd_data[COORD_W-1:0]), dz)} <=
                {1'b0, match_tol});

  assign rd_en     = (state == S_SCAN) && (ptr < count) && !hit;
  assign scan_done = (state == S_SCAN) && !rd_valid && (ptr == count);
  assign wr_en     = scan_done && (dist_acc < range_sq) &&
                     (count < CNT_W'(MAX_ENTRIES));
  assign out_load  = (state == S_RES) && (!out_valid || !out_stall);

  ddt_ram #(
    .WIDTH(POS_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[IDX_W-1:0]),
    .wdata({dx, dy, dz}),
    .re   (rd_en),
    .raddr(ptr[IDX_W-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      match_tol <= TOL_RESET;
      range_sq  <= RANGE_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MATCH_TOL: match_tol <= cfg_data[TOL_W-1:0];
          REG_RANGE_SQ:  range_sq  <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dx       <= det_x;
            dy       <= det_y;
            dz       <= det_z;
            rx       <= robot_x;
            ry       <= robot_y;
            rz       <= robot_z;
            axis     <= 2'd0;
            dist_acc <= '0;
            ptr      <= '0;
            rd_valid <= 1'b0;
            if (det_invalid) begin
              res_status <= ST_INVALID;
              res_idx    <= '0;
              res_count  <= count;
              state      <= S_RES;
            end else begin
              state <= S_DIST;
            end
          end
        end
        S_DIST: begin
          // Product of one axis is registered, then added on the next cycle.
          prod <= axis_mag * axis_mag;
          if (axis != 2'd0) begin
            dist_acc <= dist_acc + LIM_W'(prod);
          end
          axis <= axis + 2'd1;
          if (axis == 2'd3) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= rd_en;
          if (rd_en) begin
            rd_idx <= ptr[IDX_W-1:0];
            ptr    <= ptr + CNT_W'(1);
          end
          if (hit) begin
            res_status <= ST_DUPLICATE;
            res_idx    <= rd_idx;
            res_count  <= count;
            state      <= S_RES;
          end else if (scan_done) begin
            if (dist_acc >= range_sq) begin
              res_status <= ST_RANGE;
              res_idx    <= '0;
              res_count  <= count;
            end else if (!wr_en) begin
              res_status <= ST_FULL;
              res_idx    <= '0;
              res_count  <= count;
            end else begin
              res_status <= ST_ADDED;
              res_idx    <= count[IDX_W-1:0];
              res_count  <= count + CNT_W'(1);
              count      <= count + CNT_W'(1);
            end
            state <= S_RES;
          end
        end
        S_RES: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output payload loads together with out_valid when the result moves over.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      entry_index <= OUT_IDX_W'(res_idx);
      entry_count <= OUT_CNT_W'(res_count);
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the detection dedup table
// Feeds detections through a bursty driver and checks every result against a
// local prediction of the table: duplicate box, range gate, full table and
// invalid detections, over several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import ddt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [TOL_W-1:0]     TOL_MAX     = '1;
  localparam logic [LIM_W-1:0]     LIM_MAX     = '1;
  localparam int                   HOLD_CYCLES = 800;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    logic invalid;
    pos_t det;
    pos_t robot;
  } det_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] count;
  } table_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  det_invalid = 1'b0;
  coord_t                det_x = '0;
  coord_t                det_y = '0;
  coord_t                det_z = '0;
  coord_t                robot_x = '0;
  coord_t                robot_y = '0;
  coord_t                robot_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [OUT_IDX_W-1:0]  entry_index;
  logic [OUT_CNT_W-1:0]  entry_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  detection_dedup_table_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .det_invalid (det_invalid),
    .det_x       (det_x),
    .det_y       (det_y),
    .det_z       (det_z),
    .robot_x     (robot_x),
    .robot_y     (robot_y),
    .robot_z     (robot_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_index (entry_index),
    .entry_count (entry_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Local copy of the table and its registers.
  logic [TOL_W-1:0] tol_q = TOL_RESET;
  logic [LIM_W-1:0] lim_q = RANGE_RESET;
  pos_t             stored_pos [MAX_ENTRIES];
  int unsigned      stored_n = 0;

  det_item_t     pending_detections [$];
  table_result_t expected_results [$];
  pos_t          seen_positions [$];
  int            pushed_items = 0;
  int            accepted_items = 0;
  int            error_count = 0;

  function automatic int axis_gap(input coord_t a, input coord_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic longint range_sq(input pos_t a, input pos_t b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Runs one detection through the table and returns the result it causes.
  function automatic table_result_t predict_detection(input det_item_t it);
    table_result_t r;
    bit            found;
    found = 1'b0;
    r.status = ST_ADDED;
    r.index = '0;
    if (it.invalid) begin
      r.status = ST_INVALID;
    end else begin
      for (int i = 0; i < stored_n && !found; i++) begin
        if (axis_gap(stored_pos[i].x, it.det.x) <= int'(tol_q) &&
            axis_gap(stored_pos[i].y, it.det.y) <= int'(tol_q) &&
            axis_gap(stored_pos[i].z, it.det.z) <= int'(tol_q)) begin
          found = 1'b1;
          r.index = OUT_IDX_W'(i);
        end
      end
      if (found) begin
        r.status = ST_DUPLICATE;
      end else if (range_sq(it.det, it.robot) >= longint'(lim_q)) begin
        r.status = ST_RANGE;
      end else if (stored_n >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        stored_pos[stored_n] = it.det;
        r.index = OUT_IDX_W'(stored_n);
        stored_n++;
      end
    end
    r.count = OUT_CNT_W'(stored_n);
    return r;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function automatic void push_detection(input det_item_t it);
    pending_detections.push_back(it);
    if (!it.invalid) seen_positions.push_back(it.det);
    pushed_items++;
  endfunction

  function automatic void push_fields(input logic inv, input int dx, input int dy,
                                      input int dz, input int rx, input int ry,
                                      input int rz);
    det_item_t it;
    it.invalid = inv;
    it.det = '{x: coord_t'(dx), y: coord_t'(dy), z: coord_t'(dz)};
    it.robot = '{x: coord_t'(rx), y: coord_t'(ry), z: coord_t'(rz)};
    push_detection(it);
  endfunction

  // Moves a coordinate by a uniform step in [-span, span]; the sum wraps.
  function automatic coord_t nudge(input coord_t c, input int span);
    return coord_t'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic pos_t random_pos();
    return '{x: coord_t'($urandom), y: coord_t'($urandom), z: coord_t'($urandom)};
  endfunction

  function automatic pos_t robot_near(input pos_t p);
    pos_t r;
    r.x = nudge(p.x, (1 << $urandom_range(0, 16)) - 1);
    r.y = nudge(p.y, (1 << $urandom_range(0, 16)) - 1);
    r.z = nudge(p.z, (1 << $urandom_range(0, 16)) - 1);
    return r;
  endfunction

  // Mix of invalid items, hits around earlier detections, new detections
  // close to the robot and fully random pairs.
  function automatic void queue_random_detection(input int tol);
    det_item_t it;
    pos_t      base;
    int        pick;
    pick = $urandom_range(0, 99);
    it.invalid = 1'b0;
    it.det = random_pos();
    it.robot = random_pos();
    if (pick < 8) begin
      it.invalid = 1'b1;
    end else if (pick < 40 && seen_positions.size() != 0) begin
      base = seen_positions[$urandom_range(0, seen_positions.size() - 1)];
      it.det.x = nudge(base.x, tol + 2);
      it.det.y = nudge(base.y, tol + 2);
      it.det.z = nudge(base.z, tol + 2);
      it.robot = robot_near(it.det);
    end else if (pick < 80) begin
      it.robot = robot_near(it.det);
    end
    push_detection(it);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MATCH_TOL) tol_q = data[TOL_W-1:0];
    else if (idx == REG_RANGE_SQ) lim_q = data[LIM_W-1:0];
  endtask

  // Every item causes exactly one result, so an empty store means idle.
  task automatic wait_drained();
    while (accepted_items != pushed_items || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  det_item_t offered;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_detection(offered));
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_detections.size() != 0) begin
          offered = pending_detections.pop_front();
          det_invalid <= offered.invalid;
          det_x       <= offered.det.x;
          det_y       <= offered.det.y;
          det_z       <= offered.det.z;
          robot_x     <= offered.robot.x;
          robot_y     <= offered.robot.y;
          robot_z     <= offered.robot.z;
          in_valid    <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, with two long
  // hold-offs so the table backs up and stalls its input.
  int unsigned out_xfers = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_xfers <= out_xfers + 1;
      if (out_valid && !out_stall && (out_xfers == 59 || out_xfers == 399)) begin
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left != 1);
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(8, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Checker: each result transfer against the oldest expectation.
  table_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result: status %0d index %0d count %0d",
                             status, entry_index, entry_count));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || entry_index !== want.index ||
            entry_count !== want.count) begin
          note_error($sformatf({"mismatch: expected status %0d index %0d count %0d,",
                                " got status %0d index %0d count %0d"},
                               want.status, want.index, want.count,
                               status, entry_index, entry_count));
        end
      end
    end
  end

  initial begin
    int               phase_tol;
    logic [LIM_W-1:0] phase_lim;
    int               phase_n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings.
    push_fields(1'b1, -1, -1, -1, -1, -1, -1);
    push_fields(1'b0, 0, 0, 0, 0, 0, 0);
    push_fields(1'b0, 256, -256, 256, 0, 0, 0);          // box edge, inclusive
    push_fields(1'b0, 257, 0, 0, 0, 0, 0);               // just outside the box
    push_fields(1'b0, -32768, -32768, -32768, 32767, 32767, 32767);
    push_fields(1'b0, 768, 0, 0, 0, 0, 0);               // exactly at the limit
    push_fields(1'b0, 0, 767, 0, 0, 0, 0);               // just under the limit
    push_fields(1'b1, 0, 0, 0, 0, 0, 0);                 // would match if valid
    push_fields(1'b0, 32767, 32767, 32767, 32767, 32767, 32767);
    push_fields(1'b0, -32768, -32768, -32768, -32768, -32768, -32768);
    wait_drained();

    // Zero tolerance and the widest range; writes to unused indexes are ignored.
    write_register(REG_MATCH_TOL, '0);
    write_register(REG_RANGE_SQ, LIM_MAX);
    write_register(REG_SPARE_2, '0);
    write_register(REG_SPARE_3, '1);
    push_fields(1'b0, -32767, -32768, -32768, 32767, 32767, 32767);
    push_fields(1'b0, 0, 767, 0, 0, 0, 0);
    push_fields(1'b0, 1, 767, 0, 0, 0, 0);
    wait_drained();

    write_register(REG_RANGE_SQ, '0);
    push_fields(1'b0, 5, 5, 5, 5, 5, 5);                 // zero distance, zero limit
    push_fields(1'b0, 0, 0, 0, 5, 5, 5);
    wait_drained();

    write_register(REG_MATCH_TOL, TOL_MAX);
    push_fields(1'b0, 32767, 32767, 32767, 0, 0, 0);
    push_fields(1'b0, -32768, -32768, -32768, 0, 0, 0);

    // Random phases; the table fills early on and stays full afterwards.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin phase_tol = TOL_RESET;  phase_lim = RANGE_RESET; phase_n = 160; end
        1: begin phase_tol = 0;          phase_lim = LIM_MAX;     phase_n = 120; end
        2: begin
          phase_tol = TOL_MAX;
          phase_lim = {4'($urandom_range(0, 15)), $urandom};
          phase_n = 100;
        end
        3: begin
          phase_tol = $urandom_range(1, 2000);
          phase_lim = '0;
          phase_n = 80;
        end
        4: begin phase_tol = 1;          phase_lim = LIM_MAX;     phase_n = 100; end
        default: begin
          phase_tol = $urandom_range(0, 32767);
          phase_lim = LIM_W'($urandom_range(0, 4000000));
          phase_n = 140;
        end
      endcase
      wait_drained();
      write_register(REG_MATCH_TOL, CFG_DATA_W'(phase_tol));
      write_register(REG_RANGE_SQ, phase_lim);
      repeat (phase_n) queue_random_detection(phase_tol);
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
